>>> sv/asp_pkg.sv
// Shared types and codes for the sweep-and-prune broad-phase block.
package asp_pkg;

  localparam int unsigned FieldCoordBits = 24;

  localparam logic [1:0] KindAdd    = 2'd0;
  localparam logic [1:0] KindRemove = 2'd1;
  localparam logic [1:0] KindTest   = 2'd2;
  localparam logic [1:0] KindUnused = 2'd3;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;

  typedef struct packed {
    logic [1:0]                       kind;
    logic [7:0]                       box_id;
    logic [7:0]                       owner_id;
    logic signed [FieldCoordBits-1:0] min_x;
    logic signed [FieldCoordBits-1:0] min_y;
    logic signed [FieldCoordBits-1:0] min_z;
    logic signed [FieldCoordBits-1:0] max_x;
    logic signed [FieldCoordBits-1:0] max_y;
    logic signed [FieldCoordBits-1:0] max_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       pair_valid;
    logic [7:0] first_owner;
    logic [7:0] second_owner;
    logic       last;
  } out_item_t;

endpackage

>>> sv/asp_box_mem.sv
// Box store: one synchronous memory holding id, owner and corners per slot.
module asp_box_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 160,
  parameter int unsigned AW    = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/aabb_sweep_and_prune.sv
// Top level of the sweep-and-prune broad phase: sequencer around the box store.
// An add item or an unused kind gives its result from the output register in the
// cycle after it is taken. A remove searches the store from slot 0, reading and
// checking one slot at a time; when it finds the id it reads the last box and
// writes it into the found slot, giving its result with that write, and an absent
// id gives its result once every stored box has been checked. A test item first
// runs a stable insertion sort on min x through the box memory, which has one read
// and one write port (one read and one write per cycle), and then sweeps the sorted
// store, reading the later box of each candidate pair through the same read port.
// The memory port sets the rate. Results leave through an output register; the
// next item is taken only once all results of the current one have been
// delivered.
module aabb_sweep_and_prune #(
  parameter int unsigned MAX_BOXES  = 8,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  asp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output asp_pkg::out_item_t  out_data
);

  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned WIDTH = 16 + 6 * COORD_BITS;
  localparam int unsigned MaxPairs = 28;

  typedef struct packed {
    logic [7:0]                   owner;
    logic [7:0]                   bid;
    logic signed [COORD_BITS-1:0] lx;
    logic signed [COORD_BITS-1:0] ly;
    logic signed [COORD_BITS-1:0] lz;
    logic signed [COORD_BITS-1:0] hx;
    logic signed [COORD_BITS-1:0] hy;
    logic signed [COORD_BITS-1:0] hz;
  } box_t;

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StFindRd  = 4'd1;
  localparam logic [3:0] StFindCk  = 4'd2;
  localparam logic [3:0] StRmLast  = 4'd3;
  localparam logic [3:0] StRmWr    = 4'd4;
  localparam logic [3:0] StSortKey = 4'd5;
  localparam logic [3:0] StSortRd  = 4'd6;
  localparam logic [3:0] StSortCk  = 4'd7;
  localparam logic [3:0] StSortPut = 4'd8;
  localparam logic [3:0] StSwA     = 4'd9;
  localparam logic [3:0] StSwB     = 4'd10;
  localparam logic [3:0] StSwCk    = 4'd11;
  localparam logic [3:0] StEmit    = 4'd12;
  localparam logic [3:0] StWait    = 4'd13;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] i_idx;
  logic [CW-1:0] j_idx;
  logic [4:0]    pairs;
  logic [7:0]    rm_id;
  box_t          key;
  box_t          box_a;
  box_t          rd_box;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  box_t          wr_box;
  logic [AW-1:0] rd_addr;
  logic          wait_done;
  logic          emit;
  asp_pkg::out_item_t emit_data;

  asp_box_mem #(.DEPTH(MAX_BOXES), .WIDTH(WIDTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_box),
    .rd_addr (rd_addr),
    .rd_data (rd_box)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != StIdle) || !out_free;

  function automatic logic signed [COORD_BITS-1:0] cut(
    input logic signed [asp_pkg::FieldCoordBits-1:0] v);
    cut = COORD_BITS'(v);
  endfunction

  box_t new_box;
  always_comb begin
    new_box.owner = in_data.owner_id;
    new_box.bid   = in_data.box_id;
    new_box.lx    = cut(in_data.min_x);
    new_box.ly    = cut(in_data.min_y);
    new_box.lz    = cut(in_data.min_z);
    new_box.hx    = cut(in_data.max_x);
    new_box.hy    = cut(in_data.max_y);
    new_box.hz    = cut(in_data.max_z);
  end

  logic ovl;
  assign ovl = !(box_a.hx < rd_box.lx || box_a.hy < rd_box.ly || box_a.hz < rd_box.lz ||
                 rd_box.hx < box_a.lx || rd_box.hy < box_a.ly || rd_box.hz < box_a.lz);

  logic accept;
  assign accept = in_valid && !in_stall;

  // Memory port control, decided by state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_box  = key;
    rd_addr = '0;
    unique case (state)
      StIdle: begin
        if (accept && in_data.kind == asp_pkg::KindAdd && count < CW'(MAX_BOXES)) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
          wr_box  = new_box;
        end
      end
      StFindRd:  rd_addr = i_idx[AW-1:0];
      StRmLast:  rd_addr = AW'(count - 1'b1);
      StRmWr: begin
        wr_en   = 1'b1;
        wr_addr = i_idx[AW-1:0];
        wr_box  = rd_box;
      end
      StSortKey: rd_addr = i_idx[AW-1:0];
      StSortRd:  rd_addr = AW'(j_idx - 1'b1);
      StSortCk: begin
        if (rd_box.lx > key.lx) begin
          wr_en   = 1'b1;
          wr_addr = j_idx[AW-1:0];
          wr_box  = rd_box;
        end
      end
      StSortPut: begin
        wr_en   = 1'b1;
        wr_addr = j_idx[AW-1:0];
        wr_box  = key;
      end
      StSwA:     rd_addr = i_idx[AW-1:0];
      // The later box at j is read again while it is checked and while its pair waits.
      StSwB, StSwCk, StEmit: rd_addr = j_idx[AW-1:0];
      default: ;
    endcase
  end

  // Result to load into the output register this cycle, if any.
  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    unique case (state)
      StIdle: begin
        if (accept && in_data.kind != asp_pkg::KindRemove &&
            in_data.kind != asp_pkg::KindTest) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
          if (in_data.kind == asp_pkg::KindAdd && count >= CW'(MAX_BOXES)) begin
            emit_data.status = asp_pkg::StatusFull;
          end
        end
      end
      StFindRd: begin
        if (i_idx >= count) begin
          emit             = 1'b1;
          emit_data.status = asp_pkg::StatusNotFound;
          emit_data.last   = 1'b1;
        end
      end
      StRmWr: begin
        emit           = 1'b1;
        emit_data.last = 1'b1;
      end
      StEmit: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_data.pair_valid   = 1'b1;
          emit_data.first_owner  = box_a.owner;
          emit_data.second_owner = rd_box.owner;
        end
      end
      StWait: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_data <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      count     <= '0;
      i_idx     <= '0;
      j_idx     <= '0;
      pairs     <= '0;
      wait_done <= 1'b0;
    end else begin
      unique case (state)
        StIdle: begin
          if (accept) begin
            rm_id <= in_data.box_id;
            pairs <= '0;
            i_idx <= (in_data.kind == asp_pkg::KindTest) ? CW'(1) : '0;
            if (in_data.kind == asp_pkg::KindAdd && count < CW'(MAX_BOXES)) begin
              count <= count + 1'b1;
            end
            if (in_data.kind == asp_pkg::KindRemove) begin
              state <= StFindRd;
            end else if (in_data.kind == asp_pkg::KindTest) begin
              state <= StSortKey;
            end
          end
        end
        StFindRd: begin
          if (i_idx >= count) begin
            state <= StIdle;
          end else begin
            state <= StFindCk;
          end
        end
        StFindCk: begin
          if (rd_box.bid == rm_id) begin
            state <= StRmLast;
          end else begin
            i_idx <= i_idx + 1'b1;
            state <= StFindRd;
          end
        end
        StRmLast: state <= StRmWr;
        StRmWr: begin
          count <= count - 1'b1;
          state <= StIdle;
        end
        StSortKey: begin
          if (i_idx >= count) begin
            i_idx <= '0;
            j_idx <= CW'(1);
            state <= StSwA;
          end else begin
            j_idx <= i_idx;
            state <= StSortRd;
          end
        end
        StSortRd: begin
          if (j_idx == i_idx) begin
            key <= rd_box;
          end
          if (j_idx == '0) begin
            state <= StSortPut;
          end else begin
            state <= StSortCk;
          end
        end
        StSortCk: begin
          if (rd_box.lx > key.lx) begin
            j_idx <= j_idx - 1'b1;
            state <= StSortRd;
          end else begin
            state <= StSortPut;
          end
        end
        StSortPut: begin
          i_idx <= i_idx + 1'b1;
          state <= StSortKey;
        end
        // Sweep: box_a is the earlier box, rd_box the later candidate.
        StSwA: begin
          if (i_idx >= count) begin
            state <= StWait;
            wait_done <= 1'b1;
          end else begin
            j_idx <= i_idx + 1'b1;
            state <= StSwB;
          end
        end
        StSwB: begin
          if (j_idx == i_idx + 1'b1) begin
            box_a <= rd_box;
          end
          if (j_idx >= count) begin
            i_idx <= i_idx + 1'b1;
            state <= StSwA;
          end else begin
            state <= StSwCk;
          end
        end
        StSwCk: begin
          if (rd_box.lx > box_a.hx) begin
            i_idx <= i_idx + 1'b1;
            state <= StSwA;
          end else if (ovl && pairs < 5'(MaxPairs)) begin
            state <= StEmit;
          end else begin
            j_idx <= j_idx + 1'b1;
            state <= StSwB;
          end
        end
        StEmit: begin
          if (out_free) begin
            pairs <= pairs + 1'b1;
            j_idx <= j_idx + 1'b1;
            state <= StSwB;
          end
        end
        StWait: begin
          if (out_free) begin
            wait_done <= 1'b0;
            state     <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // StSwB loads box i into box_a only when j is i+1; the read port holds box j
  // through the check and any wait to emit its pair.

  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_BOXES))
    else $error("box count above store size");
  assert property (@(posedge clk) disable iff (rst) accept |-> state == StIdle)
    else $error("item accepted while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.pair_valid) |-> !out_data.last)
    else $error("pair result marked last");
  assert property (@(posedge clk) disable iff (rst) wait_done |-> state == StWait)
    else $error("end marker flag outside wait state");

endmodule

>>> dv/aabb_sweep_and_prune_checker.sv
// Checker for the sweep-and-prune block: predicts the results of each item and compares them.
module aabb_sweep_and_prune_checker #(
  parameter int unsigned MAX_BOXES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  asp_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  asp_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]         bid;
    logic [7:0]         own;
    logic signed [23:0] lx, ly, lz, hx, hy, hz;
  } box_t;

  box_t               boxes[MAX_BOXES];
  int                 n_boxes;
  asp_pkg::out_item_t expected_results[$];

  assign pending = expected_results.size();

  function automatic asp_pkg::out_item_t mk(logic [1:0] st, logic pv, logic [7:0] a,
                                            logic [7:0] b, logic lst);
    asp_pkg::out_item_t r;
    r.status = st;
    r.pair_valid = pv;
    r.first_owner = a;
    r.second_owner = b;
    r.last = lst;
    return r;
  endfunction

  function automatic bit boxes_touch(box_t a, box_t b);
    return !(a.hx < b.lx || a.hy < b.ly || a.hz < b.lz ||
             b.hx < a.lx || b.hy < a.ly || b.hz < a.lz);
  endfunction

  task automatic predict_item(asp_pkg::in_item_t it);
    box_t nb, tmp;
    int   j, k;
    bit   found;
    k = 0;
    found = 0;
    if (it.kind == asp_pkg::KindAdd) begin
      if (n_boxes >= MAX_BOXES) begin
        expected_results.push_back(mk(asp_pkg::StatusFull, 1'b0, 8'd0, 8'd0, 1'b1));
      end else begin
        nb.bid = it.box_id;
        nb.own = it.owner_id;
        nb.lx = it.min_x;
        nb.ly = it.min_y;
        nb.lz = it.min_z;
        nb.hx = it.max_x;
        nb.hy = it.max_y;
        nb.hz = it.max_z;
        boxes[n_boxes] = nb;
        n_boxes++;
        expected_results.push_back(mk(asp_pkg::StatusOk, 1'b0, 8'd0, 8'd0, 1'b1));
      end
    end else if (it.kind == asp_pkg::KindRemove) begin
      for (int i = 0; i < n_boxes && !found; i++) begin
        if (boxes[i].bid == it.box_id) begin
          boxes[i] = boxes[n_boxes-1];
          n_boxes--;
          found = 1;
        end
      end
      expected_results.push_back(mk(found ? asp_pkg::StatusOk : asp_pkg::StatusNotFound,
                                    1'b0, 8'd0, 8'd0, 1'b1));
    end else if (it.kind == asp_pkg::KindTest) begin
      // Stable insertion sort on min x; the new order is kept in the store.
      for (int i = 1; i < n_boxes; i++) begin
        tmp = boxes[i];
        j = i;
        while (j > 0 && boxes[j-1].lx > tmp.lx) begin
          boxes[j] = boxes[j-1];
          j--;
        end
        boxes[j] = tmp;
      end
      for (int i = 0; i < n_boxes; i++) begin
        for (int m = i + 1; m < n_boxes; m++) begin
          if (boxes[m].lx > boxes[i].hx) break;
          if (boxes_touch(boxes[i], boxes[m]) && k < 28) begin
            expected_results.push_back(mk(asp_pkg::StatusOk, 1'b1, boxes[i].own,
                                          boxes[m].own, 1'b0));
            k++;
          end
        end
      end
      expected_results.push_back(mk(asp_pkg::StatusOk, 1'b0, 8'd0, 8'd0, 1'b1));
    end else begin
      expected_results.push_back(mk(asp_pkg::StatusOk, 1'b0, 8'd0, 8'd0, 1'b1));
    end
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    asp_pkg::out_item_t want;
    if (rst) begin
      n_boxes = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
          if (out_data.pair_valid !== want.pair_valid)
            report_mismatch($sformatf("pair_valid %0b, want %0b", out_data.pair_valid,
                                      want.pair_valid));
          if (out_data.first_owner !== want.first_owner)
            report_mismatch($sformatf("first_owner %0d, want %0d", out_data.first_owner,
                                      want.first_owner));
          if (out_data.second_owner !== want.second_owner)
            report_mismatch($sformatf("second_owner %0d, want %0d", out_data.second_owner,
                                      want.second_owner));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_data.last, want.last));
        end
      end
      if (in_valid && !in_stall) predict_item(in_data);
    end
  end

endmodule

>>> dv/aabb_sweep_and_prune_tb.sv
// Testbench top for the sweep-and-prune block: stimulus, clock, reset and verdict.
module aabb_sweep_and_prune_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk, rst;
  logic               in_valid, in_stall, out_valid, out_stall;
  asp_pkg::in_item_t  in_data;
  asp_pkg::out_item_t out_data;
  int                 fail_count, pending;
  int                 send_idle_pct, recv_stall_pct;

  aabb_sweep_and_prune u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  aabb_sweep_and_prune_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("aabb_sweep_and_prune_tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'sh800000 + 24'($urandom_range(3));
      1: return 24'sh7FFFFF - 24'($urandom_range(3));
      default: return 24'($urandom());
    endcase
  endfunction

  // Boxes mostly clustered around a small region so that overlaps are common.
  function automatic asp_pkg::in_item_t box_item(logic [7:0] bid);
    asp_pkg::in_item_t it;
    logic signed [23:0] cx, cy, cz;
    it = '0;
    it.kind = asp_pkg::KindAdd;
    it.box_id = bid;
    it.owner_id = 8'($urandom());
    if ($urandom_range(9) == 0) begin
      it.min_x = rand_coord(); it.min_y = rand_coord(); it.min_z = rand_coord();
      it.max_x = rand_coord(); it.max_y = rand_coord(); it.max_z = rand_coord();
    end else begin
      cx = $signed(24'($urandom_range(2000))) - 24'sd1000;
      cy = $signed(24'($urandom_range(2000))) - 24'sd1000;
      cz = $signed(24'($urandom_range(2000))) - 24'sd1000;
      it.min_x = cx; it.min_y = cy; it.min_z = cz;
      it.max_x = cx + $signed(24'($urandom_range(600)));
      it.max_y = cy + $signed(24'($urandom_range(600)));
      it.max_z = cz + $signed(24'($urandom_range(600)));
    end
    return it;
  endfunction

  // Valid stays up after the accepting edge; the next call either idles or
  // presents the next item in that same step.
  task automatic send(asp_pkg::in_item_t it);
    while (($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_op(logic [1:0] k, logic [7:0] bid);
    asp_pkg::in_item_t it;
    it = $urandom() ? box_item(bid) : '0;
    it.kind = k;
    it.box_id = bid;
    send(it);
  endtask

  initial begin
    asp_pkg::in_item_t it;
    int sel;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty test, extremes, duplicates, full store, absent remove, kind 3.
    send_op(asp_pkg::KindTest, 0);
    send_op(asp_pkg::KindRemove, 8'hFF);
    it = '0;
    it.min_x = 24'sh800000; it.min_y = 24'sh800000; it.min_z = 24'sh800000;
    it.max_x = 24'sh7FFFFF; it.max_y = 24'sh7FFFFF; it.max_z = 24'sh7FFFFF;
    it.box_id = 8'hFF; it.owner_id = 8'hFF;
    send(it);
    it.box_id = 8'h00; it.owner_id = 8'h00;
    it.max_x = 24'sh800000;
    send(it);
    it = box_item(8'hFF);
    it.min_x = 24'sh7FFFFF; it.max_x = 24'sh800000;
    send(it);
    for (int i = 0; i < 6; i++) send(box_item(8'(i + 1)));
    send_op(asp_pkg::KindTest, 0);
    send_op(asp_pkg::KindRemove, 8'hFF);
    send_op(asp_pkg::KindRemove, 8'hFF);
    send_op(asp_pkg::KindRemove, 8'hAA);
    send_op(asp_pkg::KindUnused, 0);
    send_op(asp_pkg::KindTest, 0);
    for (int i = 0; i < 6; i++) send_op(asp_pkg::KindRemove, 8'(i));
    send_op(asp_pkg::KindTest, 0);

    // Random items under each idling pattern.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int i = 0; i < 20; i++) begin
        sel = $urandom_range(99);
        if (sel < 45) send(box_item(8'($urandom_range(15))));
        else if (sel < 70) send_op(asp_pkg::KindRemove, 8'($urandom_range(16)));
        else if (sel < 97) send_op(asp_pkg::KindTest, 8'($urandom()));
        else send_op(asp_pkg::KindUnused, 8'($urandom()));
      end
    end
    in_valid <= 0;

    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("aabb_sweep_and_prune_tb: PASS");
    end else begin
      $display("aabb_sweep_and_prune_tb: FAIL");
    end
    $finish;
  end
endmodule
